// ----- rtl/pusa_pkg.sv -----
// Package for the paged uniform slot allocator: sizes, op and status codes, types.
// No dependencies.
package pusa_pkg;
  localparam int PAGE_BYTES  = 65536;
  localparam int ALIGN_BYTES = 256;
  localparam int MAX_PAGES   = 16;
  localparam int FREE_DEPTH  = 64;
  localparam int LIVE_DEPTH  = 64;

  localparam int PG_W  = 4;
  localparam int OFF_W = 16;
  localparam int SZ_W  = 17;
  localparam int PCNT_W = $clog2(MAX_PAGES + 1);
  localparam int FI_W  = $clog2(FREE_DEPTH);
  localparam int FC_W  = $clog2(FREE_DEPTH + 1);
  localparam int LI_W  = $clog2(LIVE_DEPTH);
  localparam int PI_W  = $clog2(MAX_PAGES);
  localparam int AL_SH = $clog2(ALIGN_BYTES);

  localparam logic [2:0] OP_ALLOC   = 3'd0;
  localparam logic [2:0] OP_RELEASE = 3'd1;
  localparam logic [2:0] OP_UPDATE  = 3'd2;
  localparam logic [2:0] OP_CHECK   = 3'd3;
  localparam logic [2:0] OP_CLEAR   = 3'd4;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_INVALID = 3'd1;
  localparam logic [2:0] ST_NOPAGE  = 3'd2;
  localparam logic [2:0] ST_BADSIZE = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;

  // controller -> datapath
  typedef struct packed {
    logic load;        // capture input beat
    logic live_clr;    // reset live scan
    logic live_step;   // advance live scan
    logic free_clr;
    logic free_step;   // advance free scan (compare entry)
    logic shift_step;  // move one free entry down
    logic page_clr;
    logic page_step;
    logic commit;      // apply result and fill output
    logic out_take;
  } pusa_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic live_done;
    logic free_done;
    logic free_hit;
    logic shift_done;
    logic page_done;
    logic page_hit;
    logic out_full;
  } pusa_sts_t;

  // rounded size; 18 bits so 65536+ is caught
  function automatic logic [SZ_W:0] round_up(input logic [SZ_W-1:0] v);
    logic [SZ_W:0] t;
    t = {1'b0, v} + (SZ_W+1)'(ALIGN_BYTES - 1);
    return (t >> AL_SH) << AL_SH;
  endfunction
endpackage

// ----- rtl/pusa_ctrl.sv -----
// Controller for the slot allocator: sequences scans of live, free and page tables.
// Depends on pusa_pkg.
module pusa_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  pusa_pkg::pusa_sts_t sts,
  input  logic               out_ready,
  output pusa_pkg::pusa_cmd_t cmd
);
  import pusa_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LIVE  = 3'd1;
  localparam logic [2:0] S_FREE  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_PAGE  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    cmd.out_take = sts.out_full && out_ready;
    unique case (state)
      S_IDLE: if (in_valid) begin
        cmd.load = 1'b1; cmd.live_clr = 1'b1; cmd.free_clr = 1'b1; cmd.page_clr = 1'b1;
        state_next = S_LIVE;
      end
      S_LIVE: begin
        cmd.live_step = 1'b1;
        if (sts.live_done) state_next = S_FREE;
      end
      S_FREE: begin
        if (sts.free_done) begin
          state_next = sts.free_hit ? S_SHIFT : S_PAGE;
        end else begin
          cmd.free_step = 1'b1;
        end
      end
      S_SHIFT: begin
        if (sts.shift_done) state_next = S_DONE;
        else cmd.shift_step = 1'b1;
      end
      S_PAGE: begin
        if (sts.page_done) state_next = S_DONE;
        else cmd.page_step = 1'b1;
      end
      S_DONE: if (!sts.out_full || out_ready) begin
        cmd.commit = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

// ----- rtl/pusa_dp.sv -----
// Datapath for the slot allocator: tables, scan pointers, result register.
// Depends on pusa_pkg.
module pusa_dp (
  input  logic                clk,
  input  logic                rst,
  input  pusa_pkg::pusa_cmd_t cmd,
  output pusa_pkg::pusa_sts_t sts,
  input  logic [2:0]          op,
  input  logic [16:0]         size,
  input  logic [3:0]          page,
  input  logic [15:0]         offset,
  input  logic [31:0]         handle,
  output logic                out_valid,
  output logic [2:0]          status,
  output logic [3:0]          out_page,
  output logic [15:0]         out_offset,
  output logic [31:0]         out_handle,
  output logic                is_valid,
  output logic                no_overwrite
);
  import pusa_pkg::*;

  localparam int REC_W = PG_W + OFF_W + SZ_W + 1;

  // captured beat
  logic [2:0]       r_op;
  logic [SZ_W-1:0]  r_size;
  logic [PG_W-1:0]  r_page;
  logic [OFF_W-1:0] r_off;
  logic [31:0]      r_handle;
  logic [SZ_W:0]    need;

  // tables
  logic [SZ_W:0]        page_cursor [MAX_PAGES];
  logic [MAX_PAGES-1:0] page_written;
  logic [PCNT_W-1:0]    pages_in_use;
  logic [REC_W-1:0]     free_mem [FREE_DEPTH];
  logic [FC_W-1:0]      free_count;
  logic [31:0]          live_mem [LIVE_DEPTH];
  logic [LIVE_DEPTH-1:0] live_marks;
  logic [31:0]          next_handle;

  // scan state
  logic [LI_W:0]    li;
  logic             hit_live, has_empty;
  logic [LI_W-1:0]  live_idx, empty_idx;
  logic [31:0]      live_key;
  logic [31:0]      lrd;
  logic [LI_W-1:0]  lrd_idx;
  logic             lrd_vld;
  logic [FC_W-1:0]  fi;
  logic [FC_W-1:0]  frd;
  logic             fhit;
  logic [REC_W-1:0] frec, fsel;
  logic [PCNT_W-1:0] pi;
  logic             phit;
  logic [PI_W-1:0]  psel;
  logic [SZ_W:0]    pcur;

  assign live_key = (r_op == OP_ALLOC) ? next_handle : r_handle;
  assign need = (r_op == OP_ALLOC) ? round_up(r_size) : '0;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_op <= op; r_size <= size; r_page <= page; r_off <= offset; r_handle <= handle;
    end
  end

  // live table: registered read, compared in the following cycle
  always_ff @(posedge clk) begin
    lrd <= live_mem[li[LI_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.live_clr) begin
      li <= '0; hit_live <= 1'b0; has_empty <= 1'b0; lrd_vld <= 1'b0;
    end else if (cmd.live_step) begin
      lrd_vld <= (li < (LI_W+1)'(LIVE_DEPTH));
      lrd_idx <= li[LI_W-1:0];
      if (li < (LI_W+1)'(LIVE_DEPTH)) li <= li + 1'b1;
      if (lrd_vld) begin
        if (!live_marks[lrd_idx]) begin
          if (!has_empty) begin has_empty <= 1'b1; empty_idx <= lrd_idx; end
        end else if (lrd == live_key && !hit_live) begin
          hit_live <= 1'b1; live_idx <= lrd_idx;
        end
      end
    end
  end

  // free list: registered read; during a shift the read runs one entry ahead
  assign frd = cmd.shift_step ? fi + FC_W'(2) : (fhit ? fi + FC_W'(1) : fi);

  always_ff @(posedge clk) begin
    frec <= free_mem[frd[FI_W-1:0]];
  end

  logic fprimed;
  always_ff @(posedge clk) begin
    if (cmd.free_clr) begin
      fi <= '0; fhit <= 1'b0; fprimed <= 1'b0;
    end else if (cmd.free_step) begin
      if (fprimed && frec[SZ_W:0] == need) begin
        fhit <= 1'b1; fsel <= frec; fi <= fi - 1'b1;
      end else begin
        fi <= fi + 1'b1;
      end
      fprimed <= (fi < free_count);
    end else if (cmd.shift_step) begin
      fi <= fi + 1'b1;
    end
  end

  // skip free scan for non-alloc or when the beat is invalid
  logic alloc_go;
  assign alloc_go = (r_op == OP_ALLOC) && r_size != '0 && need <= (SZ_W+1)'(PAGE_BYTES)
                    && (hit_live || has_empty);

  assign sts.live_done  = (li == (LI_W+1)'(LIVE_DEPTH)) && !lrd_vld;
  assign sts.free_done  = !alloc_go || fhit || (fprimed == 1'b0 && fi >= free_count
                          && fi != '0) || (free_count == '0)
                          || (fprimed && fi > free_count);
  assign sts.free_hit   = alloc_go && fhit;
  assign sts.shift_done = (fi + 1'b1 >= free_count);
  assign sts.page_done  = !alloc_go || phit || pi >= pages_in_use;
  assign sts.page_hit   = phit;

  // page scan
  always_ff @(posedge clk) begin
    if (cmd.page_clr) begin
      pi <= '0; phit <= 1'b0;
    end else if (cmd.page_step) begin
      if (page_cursor[pi[PI_W-1:0]] + need <= (SZ_W+1)'(PAGE_BYTES)) begin
        phit <= 1'b1; psel <= pi[PI_W-1:0]; pcur <= page_cursor[pi[PI_W-1:0]];
      end else begin
        pi <= pi + 1'b1;
      end
    end
  end

  // free list writes: shift or push
  logic rel_ok, upd_ok, vld;
  assign vld = hit_live && ({1'b0, r_page} < (PG_W+1)'(pages_in_use));
  assign rel_ok = (r_op == OP_RELEASE) && vld && free_count < FC_W'(FREE_DEPTH);
  assign upd_ok = (r_op == OP_UPDATE) && vld;

  always_ff @(posedge clk) begin
    if (cmd.shift_step)
      free_mem[fi[FI_W-1:0]] <= frec;
    else if (cmd.commit && rel_ok)
      free_mem[free_count[FI_W-1:0]] <= {r_page, r_off, round_up(r_size)};
  end

  logic new_page, alloc_ok;
  assign new_page = !fhit && !phit && pages_in_use < PCNT_W'(MAX_PAGES);
  assign alloc_ok = alloc_go && (fhit || phit || new_page);

  always_ff @(posedge clk) begin
    if (cmd.commit && alloc_ok && !hit_live) live_mem[empty_idx] <= next_handle;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst || (cmd.commit && r_op == OP_CLEAR)) begin
      for (int i = 0; i < MAX_PAGES; i++) page_cursor[i] <= '0;
      page_written <= '0; pages_in_use <= '0; free_count <= '0; live_marks <= '0;
      if (rst) next_handle <= '0;
    end else if (cmd.commit) begin
      if (alloc_ok) begin
        next_handle <= next_handle + 1'b1;
        if (!hit_live) live_marks[empty_idx] <= 1'b1;
        if (fhit) free_count <= free_count - 1'b1;
        else if (phit) page_cursor[psel] <= pcur + need;
        else begin
          page_cursor[pages_in_use[PI_W-1:0]] <= need;
          page_written[pages_in_use[PI_W-1:0]] <= 1'b0;
          pages_in_use <= pages_in_use + 1'b1;
        end
      end
      if (rel_ok) begin
        live_marks[live_idx] <= 1'b0;
        free_count <= free_count + 1'b1;
      end
      if (upd_ok) page_written[r_page] <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.commit) out_valid <= 1'b1;
    else if (cmd.out_take) out_valid <= 1'b0;
  end
  assign sts.out_full = out_valid;

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status <= ST_OK; out_page <= '0; out_offset <= '0; out_handle <= '0;
      is_valid <= 1'b0; no_overwrite <= 1'b0;
      case (r_op)
        OP_ALLOC: begin
          if (r_size == '0 || need > (SZ_W+1)'(PAGE_BYTES)) status <= ST_BADSIZE;
          else if (!hit_live && !has_empty) status <= ST_FULL;
          else if (!alloc_ok) status <= ST_NOPAGE;
          else begin
            is_valid <= 1'b1; out_handle <= next_handle;
            if (fhit) begin
              out_page <= fsel[REC_W-1 -: PG_W]; out_offset <= fsel[SZ_W+OFF_W:SZ_W+1];
            end else if (phit) begin
              out_page <= PG_W'(psel); out_offset <= pcur[OFF_W-1:0];
            end else begin
              out_page <= PG_W'(pages_in_use);
            end
          end
        end
        OP_RELEASE: begin
          is_valid <= vld;
          if (!vld) status <= ST_INVALID;
          else if (!rel_ok) status <= ST_FULL;
        end
        OP_UPDATE: begin
          is_valid <= vld;
          if (!vld) status <= ST_INVALID;
          else no_overwrite <= page_written[r_page];
        end
        OP_CHECK: is_valid <= vld;
        default: ;
      endcase
    end
  end
endmodule

// ----- rtl/paged_uniform_slot_allocator.sv -----
// Top level of the paged uniform slot allocator: controller plus datapath.
// Depends on pusa_pkg, pusa_ctrl, pusa_dp.
//
//  channel | signals                                   | dir
//  in      | in_valid in_ready op size page offset handle | in
//  out     | out_valid out_ready status out_page ...       | out
//
// One beat at a time: capture, then a live-table scan (all 64 entries plus fill
// and drain of the read register), then a free-list scan, then a shift of the
// free list on an exact-size hit or a page-table scan otherwise, then commit.
// Reset is synchronous; the result register holds while out_ready is low,
// and the next beat is taken once the result is registered.
module paged_uniform_slot_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  op,
  input  logic [16:0] size,
  input  logic [3:0]  page,
  input  logic [15:0] offset,
  input  logic [31:0] handle,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [3:0]  out_page,
  output logic [15:0] out_offset,
  output logic [31:0] out_handle,
  output logic        is_valid,
  output logic        no_overwrite
);
  import pusa_pkg::*;

  pusa_cmd_t cmd;
  pusa_sts_t sts;

  pusa_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .sts(sts), .out_ready(out_ready), .cmd(cmd)
  );

  pusa_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .op(op), .size(size), .page(page), .offset(offset), .handle(handle),
    .out_valid(out_valid), .status(status), .out_page(out_page),
    .out_offset(out_offset), .out_handle(out_handle), .is_valid(is_valid),
    .no_overwrite(no_overwrite)
  );

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(out_handle))
    else $error("result changed while stalled");
  a_ok_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> !no_overwrite)
    else $error("no_overwrite set on failure");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat taken while busy");
endmodule
